### rtl/core/siq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siq_pkg: shared types and constants of the sorted insert queue
// operation codes, sequencer states and default sizing
// ----------------------------------------------------------------------------
package siq_pkg;

    // default number of entries
    localparam int DEFAULT_CAPACITY = 8;

    // payload widths
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 4;

    // operation codes carried in the operation field
    typedef enum logic [OP_W-1:0] {
        OP_TAIL    = 2'd0,
        OP_SORTED  = 2'd1,
        OP_DEQUEUE = 2'd2
    } op_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_INSERT,
        ST_DEQ_RD,
        ST_DEQ_LD,
        ST_DONE
    } state_t;

endpackage

### rtl/core/siq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siq_cmd_if / siq_rsp_if: valid/ready channels of the sorted insert queue
// command channel carries operation and value, response channel the status
// ----------------------------------------------------------------------------
interface siq_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [siq_pkg::OP_W-1:0]            operation;
    logic signed [siq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface siq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic                                accepted;
    logic signed [siq_pkg::VALUE_W-1:0]  head_value;
    logic [siq_pkg::COUNT_W-1:0]         entry_count;
    logic                                full_flag;
    logic                                empty_flag;

    modport source (output valid, output accepted, output head_value,
                    output entry_count, output full_flag, output empty_flag,
                    input ready);
    modport sink   (input valid, input accepted, input head_value,
                    input entry_count, input full_flag, input empty_flag,
                    output ready);
endinterface

### rtl/core/sorted_insert_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_queue: bounded queue of signed 32-bit values with sorted insert
// ring buffer in a single-port-write / single-port-read memory, one comparator
// ----------------------------------------------------------------------------
// One command is taken at a time and gives exactly one response transfer.
// A tail enqueue, a rejected command or an unused code goes from the command
// transfer straight to loading the response; so does a dequeue unless entries
// remain, when the new head is first read back from the memory.
// A sorted enqueue walks every stored entry from the head through the single
// memory read port and the single signed comparator, a read state and a
// compare state per entry; from the first entry not less than the new value
// on, each entry is moved back by one as the walk passes it, and the carried
// value finally lands at the tail (at once when the queue was empty).
// The next command is taken once the response is loaded into the output
// register, even while that response still waits to be taken.
// The entry memory needs no clearing: only slots holding live entries are read.
// ----------------------------------------------------------------------------
module sorted_insert_queue #(
    parameter int CAPACITY = siq_pkg::DEFAULT_CAPACITY
) (
    input  logic          clk,
    input  logic          rst_n,
    siq_cmd_if.sink       cmd,
    siq_rsp_if.source     rsp
);

    // ring pointer and count widths
    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // entry memory, indexed by physical slot
    logic signed [siq_pkg::VALUE_W-1:0] entry_mem [CAPACITY];

    // sequencer and queue state
    siq_pkg::state_t                    state_reg, state_next;
    logic [CW-1:0]                      count_reg, count_next;
    logic [PW-1:0]                      head_ptr_reg, head_ptr_next;
    logic signed [siq_pkg::VALUE_W-1:0] head_reg, head_next;

    // working registers of the current command
    logic signed [siq_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [CW-1:0]                      idx_reg, idx_next;
    logic                               acc_reg, acc_next;
    logic                               found_reg, found_next;

    // registered memory read data
    logic signed [siq_pkg::VALUE_W-1:0] rd_data_reg;

    // response output register
    logic                               out_valid_reg, out_valid_next;
    logic                               accepted_reg, accepted_next;
    logic signed [siq_pkg::VALUE_W-1:0] head_value_reg, head_value_next;
    logic [siq_pkg::COUNT_W-1:0]        entry_count_reg, entry_count_next;
    logic                               full_reg, full_next;
    logic                               empty_reg, empty_next;

    // memory port controls
    logic                               wr_en;
    logic [PW-1:0]                      wr_addr;
    logic signed [siq_pkg::VALUE_W-1:0] wr_data;
    logic [PW-1:0]                      rd_addr;

    // misc combinational
    logic                               has_room;
    logic                               val_above;

    // logical position behind the head to physical slot; the sum stays
    // below twice the capacity so one subtract wraps it
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                           input logic [CW-1:0] idx);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(idx);
        if (sum >= (CW+1)'(CAPACITY))
        begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return PW'(sum);
    endfunction

    assign has_room  = (count_reg < CW'(CAPACITY));
    // the shared comparator: stored entry strictly less than the new value
    assign val_above = (rd_data_reg < val_reg);

    // read port: new head after a dequeue, else the entry under the walk
    assign rd_addr = (state_reg == siq_pkg::ST_DEQ_RD) ? phys(head_ptr_reg, '0)
                                                       : phys(head_ptr_reg, idx_reg);

    assign cmd.ready = (state_reg == siq_pkg::ST_IDLE);

    assign rsp.valid       = out_valid_reg;
    assign rsp.accepted    = accepted_reg;
    assign rsp.head_value  = head_value_reg;
    assign rsp.entry_count = entry_count_reg;
    assign rsp.full_flag   = full_reg;
    assign rsp.empty_flag  = empty_reg;

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_ptr_next    = head_ptr_reg;
        head_next        = head_reg;
        val_next         = val_reg;
        idx_next         = idx_reg;
        acc_next         = acc_reg;
        found_next       = found_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        accepted_next    = accepted_reg;
        head_value_next  = head_value_reg;
        entry_count_next = entry_count_reg;
        full_next        = full_reg;
        empty_next       = empty_reg;
        wr_en            = 1'b0;
        wr_addr          = phys(head_ptr_reg, idx_reg);
        wr_data          = val_reg;

        case (state_reg)
            siq_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    val_next   = cmd.value;
                    acc_next   = 1'b0;
                    state_next = siq_pkg::ST_DONE;
                    case (cmd.operation)
                        siq_pkg::OP_TAIL:
                        begin
                            if (has_room)
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = phys(head_ptr_reg, count_reg);
                                wr_data    = cmd.value;
                                count_next = count_reg + 1'b1;
                                acc_next   = 1'b1;
                                if (count_reg == '0)
                                begin
                                    head_next = cmd.value;
                                end
                            end
                        end
                        siq_pkg::OP_SORTED:
                        begin
                            if (has_room)
                            begin
                                // the walk starts at the head
                                acc_next   = 1'b1;
                                idx_next   = '0;
                                found_next = 1'b0;
                                state_next = (count_reg == '0) ? siq_pkg::ST_INSERT
                                                               : siq_pkg::ST_SCAN_RD;
                            end
                        end
                        siq_pkg::OP_DEQUEUE:
                        begin
                            if (count_reg != '0)
                            begin
                                acc_next      = 1'b1;
                                count_next    = count_reg - 1'b1;
                                head_ptr_next = (head_ptr_reg == PW'(CAPACITY - 1))
                                                ? '0 : head_ptr_reg + 1'b1;
                                if (count_reg > CW'(1))
                                begin
                                    state_next = siq_pkg::ST_DEQ_RD;
                                end
                            end
                        end
                        default:
                        begin
                            acc_next = 1'b0;
                        end
                    endcase
                end
            end

            siq_pkg::ST_SCAN_RD:
            begin
                state_next = siq_pkg::ST_SCAN_CMP;
            end

            siq_pkg::ST_SCAN_CMP:
            begin
                // entries less than the new value stay put until the insert point
                if (found_reg || !val_above)
                begin
                    // drop the carried value here and carry the displaced entry
                    wr_en      = 1'b1;
                    val_next   = rd_data_reg;
                    found_next = 1'b1;
                    if (idx_reg == '0)
                    begin
                        head_next = val_reg;
                    end
                end
                idx_next   = idx_reg + 1'b1;
                state_next = ((idx_reg + 1'b1) == count_reg) ? siq_pkg::ST_INSERT
                                                             : siq_pkg::ST_SCAN_RD;
            end

            siq_pkg::ST_INSERT:
            begin
                // carried value lands at the tail
                wr_en      = 1'b1;
                count_next = count_reg + 1'b1;
                if (idx_reg == '0)
                begin
                    head_next = val_reg;
                end
                state_next = siq_pkg::ST_DONE;
            end

            siq_pkg::ST_DEQ_RD:
            begin
                state_next = siq_pkg::ST_DEQ_LD;
            end

            siq_pkg::ST_DEQ_LD:
            begin
                head_next  = rd_data_reg;
                state_next = siq_pkg::ST_DONE;
            end

            siq_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    accepted_next    = acc_reg;
                    head_value_next  = (count_reg == '0) ? '0 : head_reg;
                    entry_count_next = siq_pkg::COUNT_W'(count_reg);
                    full_next        = (count_reg == CW'(CAPACITY));
                    empty_next       = (count_reg == '0);
                    state_next       = siq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = siq_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= siq_pkg::ST_IDLE;
            count_reg     <= '0;
            head_ptr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_ptr_reg  <= head_ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        head_reg        <= head_next;
        val_reg         <= val_next;
        idx_reg         <= idx_next;
        acc_reg         <= acc_next;
        found_reg       <= found_next;
        accepted_reg    <= accepted_next;
        head_value_reg  <= head_value_next;
        entry_count_reg <= entry_count_next;
        full_reg        <= full_next;
        empty_reg       <= empty_next;
    end

    // entry memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

endmodule

### dv/tb_sorted_insert_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insert_queue: self-checking bench of the sorted insert queue
// drives tail, sorted, dequeue and spare-code commands with random gaps on both channels,
// keeps a shadow copy of the stored entries and compares every response
// ----------------------------------------------------------------------------
module tb_sorted_insert_queue;
    import siq_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;

    // the operation field is two bits wide, so the spare code is driven too
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // long receiver hold-offs, in cycles, started after these response counts
    localparam int HOLD_CYCLES  = 60;
    localparam int HOLD_AT_1    = 150;
    localparam int HOLD_AT_2    = 400;
    localparam int RANDOM_ITEMS = 500;

    typedef struct {
        logic [OP_W-1:0]            op;
        logic signed [VALUE_W-1:0]  value;
        bit                         drain_first;  // hold until every response is back
    } queue_cmd_t;

    typedef struct {
        logic                       accepted;
        logic signed [VALUE_W-1:0]  head_value;
        logic [COUNT_W-1:0]         entry_count;
        logic                       full_flag;
        logic                       empty_flag;
    } queue_status_t;

    logic clk = 1'b0;
    logic rst_n;

    siq_cmd_if cmd_ch ();
    siq_rsp_if rsp_ch ();

    sorted_insert_queue #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // commands waiting to be offered, status words waiting to be seen
    queue_cmd_t                pending_ops[$];
    queue_status_t             expected_status[$];
    // shadow of the stored entries, head at index 0
    logic signed [VALUE_W-1:0] shadow_entries[$];

    int n_cmd_xfers   = 0;
    int n_cmd_offered = 0;
    int n_rsp_xfers   = 0;
    int n_fail        = 0;
    int hold_left     = 0;
    int holds_done    = 0;

    // idle draw per transfer, with calm runs where no idling happens at all
    function automatic int draw_idle(inout bit calm, inout int run);
        if (run == 0)
        begin
            calm = ($urandom_range(0, 2) == 0);
            run  = $urandom_range(8, 40);
        end
        run--;
        return calm ? 0 : int'($urandom_range(0, 13));
    endfunction

    // applies one command to the shadow and returns the status it must report
    function automatic queue_status_t apply_queue_op(logic [OP_W-1:0] op,
                                                     logic signed [VALUE_W-1:0] value);
        queue_status_t st;
        int pos;
        st.accepted = 1'b0;
        case (op)
            OP_TAIL:
                if (shadow_entries.size() < CAPACITY)
                begin
                    shadow_entries.push_back(value);
                    st.accepted = 1'b1;
                end
            OP_SORTED:
                if (shadow_entries.size() < CAPACITY)
                begin
                    // skip entries strictly less, so it lands ahead of equal ones
                    pos = 0;
                    while (pos < shadow_entries.size() && shadow_entries[pos] < value)
                        pos++;
                    shadow_entries.insert(pos, value);
                    st.accepted = 1'b1;
                end
            OP_DEQUEUE:
                if (shadow_entries.size() > 0)
                begin
                    shadow_entries.delete(0);
                    st.accepted = 1'b1;
                end
            default:
                ;   // spare code leaves the queue alone
        endcase
        st.head_value  = (shadow_entries.size() > 0) ? shadow_entries[0] : '0;
        st.entry_count = COUNT_W'(shadow_entries.size());
        st.full_flag   = (shadow_entries.size() == CAPACITY);
        st.empty_flag  = (shadow_entries.size() == 0);
        return st;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_fail++;
        end
    endtask

    task automatic add_op(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
                          bit drain_first);
        queue_cmd_t c;
        c.op          = op;
        c.value       = value;
        c.drain_first = drain_first;
        pending_ops.push_back(c);
    endtask

    // mostly small values so that equal keys meet, plus the extremes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return VALUE_W'(int'($urandom_range(0, 8)) - 4);
            4:          return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:    return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // monitor: both channels sampled at the rising edge
    // response side first, so a stray response is caught before new work
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        queue_status_t want;
        queue_status_t got;
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_rsp_xfers++;
                got.accepted    = rsp_ch.accepted;
                got.head_value  = rsp_ch.head_value;
                got.entry_count = rsp_ch.entry_count;
                got.full_flag   = rsp_ch.full_flag;
                got.empty_flag  = rsp_ch.empty_flag;
                if (expected_status.size() == 0)
                begin
                    $error("response transfer with nothing outstanding");
                    n_fail++;
                end
                else
                begin
                    want = expected_status.pop_front();
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("head_value", want.head_value, got.head_value);
                    check_field("entry_count", want.entry_count, got.entry_count);
                    check_field("full_flag", want.full_flag, got.full_flag);
                    check_field("empty_flag", want.empty_flag, got.empty_flag);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                n_cmd_xfers++;
                expected_status.push_back(apply_queue_op(cmd_ch.operation, cmd_ch.value));
            end
        end
    end

    // ------------------------------------------------------------------------
    // command driver: changes at the falling edge
    // an offered command stays up until its transfer has been seen
    // ------------------------------------------------------------------------
    bit cmd_calm     = 1'b0;
    int cmd_run      = 0;
    int cmd_wait     = 0;

    always @(negedge clk)
    begin
        queue_cmd_t c;
        logic next_valid;
        if (rst_n && !(cmd_ch.valid && n_cmd_xfers != n_cmd_offered))
        begin
            next_valid = 1'b0;
            // last command just went through: draw the gap before the next
            if (cmd_ch.valid)
                cmd_wait = draw_idle(cmd_calm, cmd_run);
            if (cmd_wait > 0)
                cmd_wait--;
            else if (pending_ops.size() > 0
                     && !(pending_ops[0].drain_first && expected_status.size() > 0))
            begin
                c = pending_ops.pop_front();
                cmd_ch.operation <= c.op;
                cmd_ch.value     <= c.value;
                n_cmd_offered++;
                next_valid = 1'b1;
            end
            cmd_ch.valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------------
    // long receiver hold-off, counted here so the sender keeps pushing and
    // the block backs up into its command port
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (holds_done == 0 && n_rsp_xfers >= HOLD_AT_1
                 || holds_done == 1 && n_rsp_xfers >= HOLD_AT_2)
        begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    // response ready: per-transfer random stall on top of the hold-off
    bit rsp_calm     = 1'b0;
    int rsp_run      = 0;
    int rsp_wait     = 0;
    int rsp_seen     = 0;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (n_rsp_xfers != rsp_seen)
            begin
                rsp_seen = n_rsp_xfers;
                rsp_wait = draw_idle(rsp_calm, rsp_run);
            end
            else if (rsp_wait > 0)
                rsp_wait--;
            rsp_ch.ready <= (rsp_wait == 0) && (hold_left == 0);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int               fill_bias;
        logic [OP_W-1:0]  op;

        cmd_ch.valid     = 1'b0;
        cmd_ch.operation = OP_TAIL;
        cmd_ch.value     = '0;
        rsp_ch.ready     = 1'b0;
        rst_n            = 1'b0;

        // directed: empty rejects, extremes, ordering, full rejects, drain out
        add_op(OP_DEQUEUE, 32'sh5A5A_5A5A, 1'b0);   // dequeue when empty
        add_op(OP_UNUSED, 32'sh1234_5678, 1'b0);    // spare code on empty queue
        add_op(OP_SORTED, 32'sh0, 1'b0);            // sorted insert into empty queue
        add_op(OP_TAIL, 32'sh7FFF_FFFF, 1'b0);
        add_op(OP_TAIL, 32'sh8000_0000, 1'b0);
        add_op(OP_SORTED, 32'sh8000_0000, 1'b0);    // most negative becomes the head
        add_op(OP_SORTED, 32'sh5, 1'b0);
        add_op(OP_SORTED, 32'sh5, 1'b0);            // equal key goes ahead
        add_op(OP_SORTED, -32'sh1, 1'b0);
        add_op(OP_SORTED, 32'sh1, 1'b0);            // queue now full
        add_op(OP_TAIL, 32'sh3, 1'b0);              // rejected, full
        add_op(OP_SORTED, 32'sh8000_0000, 1'b0);    // rejected, full
        add_op(OP_UNUSED, 32'shFFFF_FFFF, 1'b0);    // spare code on full queue
        for (int k = 0; k < CAPACITY + 1; k++)
            add_op(OP_DEQUEUE, $urandom, 1'b0);     // drain, last one rejected

        // random: segments that lean toward filling or toward draining
        fill_bias = 50;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 30 == 0)
                fill_bias = $urandom_range(15, 85);
            if ($urandom_range(0, 99) < 3)
                op = OP_UNUSED;
            else if ($urandom_range(0, 99) < fill_bias)
                op = $urandom_range(0, 1) ? OP_SORTED : OP_TAIL;
            else
                op = OP_DEQUEUE;
            // sender pauses for a full drain at least once
            add_op(op, pick_value(), (k == 250) || ($urandom_range(0, 99) == 0));
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every command taken and every response back
        do
            @(posedge clk);
        while (pending_ops.size() != 0 || n_cmd_xfers != n_cmd_offered
               || expected_status.size() != 0);
        // room for a late stray response
        repeat (40) @(posedge clk);

        if (n_fail == 0)
            $display("tb_sorted_insert_queue OK");
        else
            $display("tb_sorted_insert_queue NOT OK");
        $finish;
    end

    // slowest correct run is far below this
    initial
    begin
        #(4_000_000);
        $display("tb_sorted_insert_queue NOT OK");
        $finish;
    end

endmodule

### files.f
rtl/core/siq_pkg.sv
rtl/core/siq_if.sv
rtl/core/sorted_insert_queue.sv
dv/tb_sorted_insert_queue.sv
